// ===== rtl/btpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types, constants and helpers of the barometric compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

  // compensation constants
  localparam logic [63:0] TFINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_BASE   = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE  = 64'd3125;
  localparam logic [63:0] ONE_Q47      = 64'h0000_8000_0000_0000;

  // one quotient bit per divider cell
  localparam int unsigned DIV_STEPS = 64;

  // configuration register indexes
  typedef enum logic [7:0] {
    CFG_TEMP_CALIB = 8'd0,
    CFG_PRESS_LO   = 8'd1,
    CFG_PRESS_HI   = 8'd2,
    CFG_PRESS_P9   = 8'd3
  } cfg_idx_e;

  // data handed from one divider cell to the next
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] den;
    logic        neg;
    logic        zero;
  } div_t;

  // sign-extend a 16-bit calibration word
  function automatic logic [63:0] sx16(input logic [15:0] w);
    sx16 = {{48{w[15]}}, w};
  endfunction

endpackage

// ===== rtl/btpc_mul64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_mul64
// Two-stage 64x64 multiplier keeping the low 64 bits (wrapping product).
// ----------------------------------------------------------------------------
module btpc_mul64 import btpc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_q;
  logic [31:0] cross_q;
  logic [31:0] lh_w;
  logic [31:0] hl_w;
  logic [63:0] p_q;

  // only the low halves of the cross products reach the kept bits
  assign lh_w = a_i[31:0] * b_i[63:32];
  assign hl_w = a_i[63:32] * b_i[31:0];

  // partial products, then the final sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q    <= a_i[31:0] * b_i[31:0];
      cross_q <= lh_w + hl_w;
      p_q     <= ll_q + {cross_q, 32'd0};
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/btpc_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_div_cell
// One restoring division step: yields one quotient bit and passes it on.
// ----------------------------------------------------------------------------
module btpc_div_cell import btpc_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t cell_i,
  output div_t cell_o
);

  logic [64:0] trial_w;
  logic [64:0] diff_w;
  logic        take_w;
  div_t        cell_q;

  assign trial_w = {cell_i.rem, cell_i.quo[63]};
  assign diff_w  = trial_w - {1'b0, cell_i.den};
  assign take_w  = trial_w >= {1'b0, cell_i.den};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q.rem  <= take_w ? diff_w[63:0] : trial_w[63:0];
      cell_q.quo  <= {cell_i.quo[62:0], take_w};
      cell_q.den  <= cell_i.den;
      cell_q.neg  <= cell_i.neg;
      cell_q.zero <= cell_i.zero;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== rtl/baro_temp_pressure_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation of raw barometer readings.
// ----------------------------------------------------------------------------
// channel   | direction | transfer contents
// s_axis    | in        | raw_temperature, raw_pressure
// m_axis    | out       | temperature_centi, pressure_q24_8; tuser pressure_valid
// cfg       | in        | register index and 64-bit write data
//
// one item per cycle while the output is not stalled
// pipeline depth is set by the 64-cell division chain and the split 64-bit multipliers
// the whole pipeline advances together; it stalls only while a result waits
// reset clears valid bits and calibration registers, payload is not reset
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation import btpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [19:0] raw_temperature, [39:20] raw_pressure
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [31:0] temperature_centi, [63:32] pressure_q24_8
  output logic [0:0]  m_axis_tuser_o,   // [0] pressure_valid
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  // stage numbers
  localparam int unsigned DivFirst = 16;
  localparam int unsigned PStage   = DivFirst + DIV_STEPS + 1;
  localparam int unsigned OutStage = PStage + 5;

  // calibration registers
  logic [47:0] temp_calib_q;
  logic [63:0] press_lo_q;
  logic [63:0] press_hi_q;
  logic [15:0] press_p9_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_lo_q   <= '0;
      press_hi_q   <= '0;
      press_p9_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TEMP_CALIB: temp_calib_q <= cfg_data_i[47:0];
        CFG_PRESS_LO:   press_lo_q   <= cfg_data_i;
        CFG_PRESS_HI:   press_hi_q   <= cfg_data_i;
        CFG_PRESS_P9:   press_p9_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // calibration words
  logic [31:0] t1_w, t2_w, t3_w;
  assign t1_w = {16'd0, temp_calib_q[15:0]};
  assign t2_w = 32'(sx16(temp_calib_q[31:16]));
  assign t3_w = 32'(sx16(temp_calib_q[47:32]));

  // pipeline control: everything moves when the output register is free
  logic              en;
  logic [OutStage:1] vld_q;

  assign en              = !vld_q[OutStage] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[OutStage];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[OutStage-1:1], s_axis_tvalid_i};
    end
  end

  // temperature path, 32-bit wrap
  logic [31:0] a1_q, d1_q, m1_q, dd2_q, v1_q, m2_q, fine_q;
  logic [19:0] adcp_q [1:12];
  logic [31:0] temp_q [5:OutStage-1];
  logic [63:0] x5_q;
  logic [31:0] t5_w;

  assign t5_w = fine_q * 32'd5 + 32'd128;

  // pressure path registers and shift lines
  logic [63:0] xx_w, xp5_w, xp2_w, y1_w, x1_w, m12_w, n15_w;
  logic [63:0] xp5_q [8:9];
  logic [63:0] xp2_q [8:9];
  logic [63:0] y_q   [10:12];
  logic [63:0] xa10_q;
  logic [63:0] den_q [13:15];
  logic [63:0] num0_q;
  div_t        div_c [0:DIV_STEPS];
  logic [63:0] p_q    [PStage:OutStage-1];
  logic        zero_q [PStage:OutStage-1];
  logic [63:0] pi_q   [PStage+3:OutStage-1];
  logic [63:0] s_w, ss_w, pi_w, e9_w;
  logic [63:0] sum_w, press_w;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1 to 5: fine temperature and temperature output
      a1_q   <= 32'(s_axis_tdata_i[19:3]) - {t1_w[30:0], 1'b0};
      d1_q   <= 32'(s_axis_tdata_i[19:4]) - t1_w;
      m1_q   <= a1_q * t2_w;
      dd2_q  <= d1_q * d1_q;
      v1_q   <= 32'($signed(m1_q) >>> 11);
      m2_q   <= 32'($signed(dd2_q) >>> 12) * t3_w;
      fine_q <= v1_q + 32'($signed(m2_q) >>> 14);
      temp_q[5] <= 32'($signed(t5_w) >>> 8);
      x5_q      <= {{32{fine_q[31]}}, fine_q} - TFINE_OFFSET;
      for (int k = 6; k <= OutStage - 1; k++) temp_q[k] <= temp_q[k-1];

      adcp_q[1] <= s_axis_tdata_i[39:20];
      for (int k = 2; k <= 12; k++) adcp_q[k] <= adcp_q[k-1];

      // stage 8 to 10: second-order terms
      xp5_q[8] <= xp5_w;
      xp5_q[9] <= xp5_q[8];
      xp2_q[8] <= xp2_w;
      xp2_q[9] <= xp2_q[8];
      y_q[10]  <= y1_w + (xp5_q[9] << 17) + (sx16(press_lo_q[63:48]) << 35);
      xa10_q   <= ONE_Q47 + 64'($signed(x1_w) >>> 8) + (xp2_q[9] << 12);
      y_q[11]  <= y_q[10];
      y_q[12]  <= y_q[11];

      // stage 13: divisor and numerator base
      den_q[13] <= 64'($signed(m12_w) >>> 33);
      num0_q    <= ((PRESS_BASE - {44'd0, adcp_q[12]}) << 31) - y_q[12];
      den_q[14] <= den_q[13];
      den_q[15] <= den_q[14];

      // stage 16: magnitudes and signs for the divider chain
      div_c[0].rem  <= '0;
      div_c[0].quo  <= n15_w[63] ? (64'd0 - n15_w) : n15_w;
      div_c[0].den  <= den_q[15][63] ? (64'd0 - den_q[15]) : den_q[15];
      div_c[0].neg  <= n15_w[63] ^ den_q[15][63];
      div_c[0].zero <= den_q[15] == 64'd0;

      // signed quotient and its companions
      p_q[PStage]    <= div_c[DIV_STEPS].neg ? (64'd0 - div_c[DIV_STEPS].quo)
                                             : div_c[DIV_STEPS].quo;
      zero_q[PStage] <= div_c[DIV_STEPS].zero;
      for (int k = PStage + 1; k <= OutStage - 1; k++) begin
        p_q[k]    <= p_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
      pi_q[PStage+3] <= pi_w;
      for (int k = PStage + 4; k <= OutStage - 1; k++) pi_q[k] <= pi_q[k-1];
    end
  end

  btpc_mul64 u_mul_xx (.clk_i, .en_i(en), .a_i(x5_q), .b_i(x5_q), .p_o(xx_w));
  btpc_mul64 u_mul_xp5 (.clk_i, .en_i(en), .a_i(x5_q), .b_i(sx16(press_hi_q[15:0])),
                        .p_o(xp5_w));
  btpc_mul64 u_mul_xp2 (.clk_i, .en_i(en), .a_i(x5_q), .b_i(sx16(press_lo_q[31:16])),
                        .p_o(xp2_w));
  btpc_mul64 u_mul_y1 (.clk_i, .en_i(en), .a_i(xx_w), .b_i(sx16(press_hi_q[31:16])),
                       .p_o(y1_w));
  btpc_mul64 u_mul_x1 (.clk_i, .en_i(en), .a_i(xx_w), .b_i(sx16(press_lo_q[47:32])),
                       .p_o(x1_w));
  btpc_mul64 u_mul_p1 (.clk_i, .en_i(en), .a_i(xa10_q), .b_i({48'd0, press_lo_q[15:0]}),
                       .p_o(m12_w));
  btpc_mul64 u_mul_sc (.clk_i, .en_i(en), .a_i(num0_q), .b_i(PRESS_SCALE), .p_o(n15_w));

  // divider chain, one quotient bit per cell
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    btpc_div_cell u_cell (
      .clk_i,
      .en_i  (en),
      .cell_i(div_c[g]),
      .cell_o(div_c[g+1])
    );
  end

  // correction terms
  assign s_w = 64'($signed(p_q[PStage]) >>> 13);

  btpc_mul64 u_mul_ss (.clk_i, .en_i(en), .a_i(s_w), .b_i(s_w), .p_o(ss_w));
  btpc_mul64 u_mul_p8 (.clk_i, .en_i(en), .a_i(p_q[PStage]),
                       .b_i(sx16(press_hi_q[63:48])), .p_o(pi_w));
  btpc_mul64 u_mul_p9 (.clk_i, .en_i(en), .a_i(ss_w), .b_i(sx16(press_p9_q)), .p_o(e9_w));

  assign sum_w   = p_q[OutStage-1] + 64'($signed(e9_w) >>> 25)
                 + 64'($signed(pi_q[OutStage-1]) >>> 19);
  assign press_w = 64'($signed(sum_w) >>> 8) + (sx16(press_hi_q[47:32]) << 4);

  // output register
  logic [31:0] out_temp_q, out_press_q;
  logic        out_pv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_temp_q  <= temp_q[OutStage-1];
      out_press_q <= zero_q[OutStage-1] ? 32'd0 : press_w[31:0];
      out_pv_q    <= !zero_q[OutStage-1];
    end
  end

  assign m_axis_tdata_o = {out_press_q, out_temp_q};
  assign m_axis_tuser_o = out_pv_q;

  // an accepted item enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[1])
    else $error("accepted item did not enter the pipeline");

  // a flagged result carries zero pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o[63:32] == 32'd0))
    else $error("invalid pressure is not zero");

  // a stalled pipeline keeps its occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule

// ===== dv/baro_temp_pressure_compensation_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_test
// Self-checking bench: drives raw reading pairs under several calibration
// sets, predicts each compensated result and compares all of its fields.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_test;
  import btpc_pkg::*;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] press_q24_8;
    logic        press_ok;
  } comp_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;   // [19:0] raw_temperature, [39:20] raw_pressure
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;        // [31:0] temperature_centi, [63:32] pressure_q24_8
  logic [0:0]  m_axis_tuser_o;        // [0] pressure_valid
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  baro_temp_pressure_compensation u_top (.*);

  always #6 clk_i = ~clk_i;

  // local copy of the calibration registers
  logic [47:0] cal_temp;
  logic [63:0] cal_lo, cal_hi;
  logic [15:0] cal_p9;

  comp_result_t expected_q[$];
  int  n_mismatch = 0, n_results = 0, n_sent = 0, n_invalid = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;

  function automatic logic [63:0] asr64(logic [63:0] x, int s);
    asr64 = $signed(x) >>> s;
  endfunction

  function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    div_trunc = (a[63] != b[63]) ? -q : q;
  endfunction

  // integer compensation of one raw pair under the current calibration
  function automatic comp_result_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
    comp_result_t r;
    logic [31:0] t1, t2, t3, a, v1, d, v2, fine;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, x, y, p, s, e1, e2;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    a = {12'd0, adc_t} >> 3;
    a = a - (t1 << 1);
    v1 = $signed(a * t2) >>> 11;
    d = ({12'd0, adc_t} >> 4) - t1;
    v2 = $signed(d * d) >>> 12;
    v2 = $signed(v2 * t3) >>> 14;
    fine = v1 + v2;
    r.temp_centi = $signed(fine * 32'd5 + 32'd128) >>> 8;
    p1 = {48'd0, cal_lo[15:0]};
    p2 = sx16(cal_lo[31:16]); p3 = sx16(cal_lo[47:32]); p4 = sx16(cal_lo[63:48]);
    p5 = sx16(cal_hi[15:0]);  p6 = sx16(cal_hi[31:16]);
    p7 = sx16(cal_hi[47:32]); p8 = sx16(cal_hi[63:48]);
    p9 = sx16(cal_p9);
    x = {{32{fine[31]}}, fine} - 64'd128000;
    y = x * x * p6;
    y = y + ((x * p5) << 17);
    y = y + (p4 << 35);
    x = asr64(x * x * p3, 8) + ((x * p2) << 12);
    x = asr64(((64'd1 << 47) + x) * p1, 33);
    r.press_q24_8 = '0;
    r.press_ok = 1'b0;
    if (x != 0) begin
      p = 64'd1048576 - {44'd0, adc_p};
      p = div_trunc(((p << 31) - y) * 64'd3125, x);
      s = asr64(p, 13);
      e1 = asr64(p9 * s * s, 25);
      e2 = asr64(p8 * p, 19);
      p = asr64(p + e1 + e2, 8) + (p7 << 4);
      r.press_q24_8 = p[31:0];
      r.press_ok = 1'b1;
    end
    return r;
  endfunction

  // random idle burst, about one time in four
  task automatic maybe_idle();
    if (idle_on && $urandom_range(3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
  endtask

  // valid stays high across back-to-back writes, the caller drops it
  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TEMP_CALIB: cal_temp = val[47:0];
      CFG_PRESS_LO:   cal_lo = val;
      CFG_PRESS_HI:   cal_hi = val;
      CFG_PRESS_P9:   cal_p9 = val[15:0];
      default: ;
    endcase
  endtask

  // valid stays high into the next pair unless an idle burst or a drain follows
  task automatic send_pair(logic [19:0] adc_t, logic [19:0] adc_p);
    maybe_idle();
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {adc_p, adc_t};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(compensate(adc_t, adc_p));
    n_sent++;
  endtask

  // drain: wait for all results, then longer than the pipeline depth, before reconfiguring
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_calib(logic [47:0] t, logic [63:0] lo, logic [63:0] hi, logic [15:0] p9);
    drain();
    write_reg(CFG_TEMP_CALIB, {$urandom, $urandom} & 64'h0 | t);
    write_reg(CFG_PRESS_LO, lo);
    write_reg(CFG_PRESS_HI, hi);
    write_reg(CFG_PRESS_P9, {{48{p9[15]}}, p9});
    cfg_valid_i <= 1'b0;
  endtask

  // a realistic calibration set close to what a sensor ships with
  task automatic set_typical_calib();
    set_calib({16'hFC18, 16'd26435, 16'd27504},
              {16'd2855, 16'hD0F8, 16'd8192 + 16'($urandom_range(200)), 16'd36477},
              {16'hD8AA + 16'($urandom_range(15)), 16'd15500, 16'hFFF9, 16'hFF9C - 16'd40},
              16'd6000);
  endtask

  // output side: random back-pressure bursts and compare of all fields
  always @(posedge clk_i) begin
    comp_result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tdata_o[31:0], m_axis_tdata_o[63:32], m_axis_tuser_o[0]};
        n_results++;
        if (!got.press_ok) n_invalid++;
        if (expected_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: temp %h/%h press %h/%h ok %b/%b (exp/act)",
                       want.temp_centi, got.temp_centi, want.press_q24_8,
                       got.press_q24_8, want.press_ok, got.press_ok);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (idle_on && $urandom_range(4) == 0) begin
        stall_left = $urandom_range(5, 1) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic test_reset_defaults();
    // all calibration zero: divisor is zero, pressure forced to zero
    send_pair(20'd0, 20'd0);
    send_pair(20'hFFFFF, 20'hFFFFF);
    send_pair(20'h80000, 20'h55555);
  endtask

  task automatic test_directed_extremes();
    logic [19:0] corner[4] = '{20'd0, 20'hFFFFF, 20'h80000, 20'h7FFFF};
    set_typical_calib();
    foreach (corner[i]) foreach (corner[j]) send_pair(corner[i], corner[j]);
    send_pair(20'd519888, 20'd415148);
    // extreme calibration words to exercise wrap in both paths
    set_calib({16'h8000, 16'h8000, 16'hFFFF}, 64'h7FFF_7FFF_8000_FFFF,
              64'h8000_7FFF_8000_7FFF, 16'h8000);
    foreach (corner[i]) send_pair(corner[i], corner[3 - i]);
    // p1 of zero: zero divisor with nonzero temperature
    set_calib(48'h7FFF_7FFF_0001, 64'h1234_5678_9ABC_0000, 64'hFFFF_FFFF_FFFF_FFFF, 16'h7FFF);
    send_pair(20'hFFFFF, 20'd12345);
    send_pair(20'd0, 20'hFFFFF);
  endtask

  task automatic test_random_calib(int n_sets, int per_set);
    repeat (n_sets) begin
      if ($urandom_range(1)) set_typical_calib();
      else set_calib(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                     16'($urandom));
      repeat (per_set) send_pair(20'($urandom), 20'($urandom));
    end
  endtask

  task automatic test_typical_stream(int n);
    set_typical_calib();
    repeat (n) send_pair(20'd400000 + 20'($urandom_range(250000)),
                         20'd200000 + 20'($urandom_range(400000)));
  endtask

  initial begin
    cal_temp = '0; cal_lo = '0; cal_hi = '0; cal_p9 = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_extremes();
    test_random_calib(12, 100);
    test_typical_stream(324);
    idle_on = 1'b0;
    test_random_calib(2, 100);
    test_typical_stream(200);
    drain();
    $display("sent %0d reading pairs over random and typical calibration sets,", n_sent);
    $display("checked %0d results (%0d with zero divisor)", n_results, n_invalid);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/btpc_pkg.sv
rtl/btpc_mul64.sv
rtl/btpc_div_cell.sv
rtl/baro_temp_pressure_compensation.sv
dv/baro_temp_pressure_compensation_test.sv
